@@ hw/rtl/lpbr_pkg.sv @@
`default_nettype none

package lpbr_pkg;

    // widths of the frame fields
    localparam int LENGTH_BITS = 32;
    localparam int ID_BITS     = 22;
    localparam int BYTE_BITS   = 8;

    localparam int HDR_CNT_W = $clog2(LENGTH_BITS + 1);
    localparam int BIT_POS_W = $clog2(BYTE_BITS);

    localparam logic [HDR_CNT_W-1:0] HDR_CNT_LAST = HDR_CNT_W'(LENGTH_BITS);
    localparam logic [BIT_POS_W-1:0] BIT_POS_TOP  = BIT_POS_W'(BYTE_BITS - 1);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_HEADER = 3'b010,
        PH_DATA   = 3'b100
    } phase_t;

    typedef struct packed {
        phase_t                 phase;
        logic [ID_BITS-1:0]     peer_id;
        logic [HDR_CNT_W-1:0]   header_count;
        logic [LENGTH_BITS-1:0] message_length;
        logic [LENGTH_BITS-1:0] bytes_received;
        logic [BIT_POS_W-1:0]   bit_position;
        logic [BYTE_BITS-1:0]   byte_shift;
    } state_t;

    localparam state_t STATE_CLEAR = '{
        phase:          PH_IDLE,
        peer_id:        '0,
        header_count:   '0,
        message_length: '0,
        bytes_received: '0,
        bit_position:   BIT_POS_TOP,
        byte_shift:     '0
    };

    typedef struct packed {
        logic [ID_BITS-1:0]   dest_id;
        logic                 ack_bit;
        logic                 ack_done;
        logic                 byte_valid;
        logic [BYTE_BITS-1:0] data_byte;
        logic                 rejected;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/lpbr_core.sv @@
`default_nettype none

module lpbr_core
    import lpbr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire logic [ID_BITS-1:0] sender_id,
    input  wire logic               bit_value,
    output result_t                 res
);

    state_t state_reg;
    state_t state_next;

    logic [LENGTH_BITS-1:0] len_shifted;
    logic [HDR_CNT_W-1:0]   cnt_inc;
    logic [BYTE_BITS-1:0]   shift_new;
    logic [LENGTH_BITS-1:0] bytes_inc;

    assign len_shifted = {state_reg.message_length[LENGTH_BITS-2:0], bit_value};
    assign cnt_inc     = state_reg.header_count + HDR_CNT_W'(1);
    assign shift_new   = {state_reg.byte_shift[BYTE_BITS-2:0], bit_value};
    assign bytes_inc   = state_reg.bytes_received + LENGTH_BITS'(1);

    always_comb
    begin
        state_next     = state_reg;
        res.dest_id    = sender_id;
        res.ack_bit    = 1'b0;
        res.ack_done   = 1'b0;
        res.byte_valid = 1'b0;
        res.data_byte  = '0;
        res.rejected   = 1'b0;

        unique case (state_reg.phase)
            PH_HEADER:
            begin
                if (sender_id != state_reg.peer_id)
                begin
                    state_next   = STATE_CLEAR;
                    res.rejected = 1'b1;
                end
                else
                begin
                    res.ack_bit               = 1'b1;
                    state_next.message_length = len_shifted;
                    state_next.header_count   = cnt_inc;
                    if (cnt_inc >= HDR_CNT_LAST)
                    begin
                        if (len_shifted == '0)
                        begin
                            res.ack_done = 1'b1;
                            state_next   = STATE_CLEAR;
                        end
                        else
                        begin
                            state_next.phase          = PH_DATA;
                            state_next.bytes_received = '0;
                            state_next.bit_position   = BIT_POS_TOP;
                            state_next.byte_shift     = '0;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                if (sender_id != state_reg.peer_id)
                begin
                    state_next   = STATE_CLEAR;
                    res.rejected = 1'b1;
                end
                else
                begin
                    res.ack_bit = 1'b1;
                    if (state_reg.bit_position == '0)
                    begin
                        res.byte_valid            = 1'b1;
                        res.data_byte             = shift_new;
                        state_next.byte_shift     = '0;
                        state_next.bit_position   = BIT_POS_TOP;
                        state_next.bytes_received = bytes_inc;
                        if (bytes_inc == state_reg.message_length)
                        begin
                            res.ack_done = 1'b1;
                            state_next   = STATE_CLEAR;
                        end
                    end
                    else
                    begin
                        state_next.byte_shift   = shift_new;
                        state_next.bit_position = state_reg.bit_position - BIT_POS_W'(1);
                    end
                end
            end
            default:
            begin
                // idle, and any stray phase code behaves as idle
                state_next = STATE_CLEAR;
                if (bit_value)
                begin
                    state_next.phase   = PH_HEADER;
                    state_next.peer_id = sender_id;
                    res.ack_bit        = 1'b1;
                end
                else
                begin
                    res.rejected = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_CLEAR;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lpbr_out_buf.sv @@
`default_nettype none

module lpbr_out_buf
    import lpbr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_res,
    output logic         can_take,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);

    // two-entry queue so the producer keeps going while a result waits
    result_t    entry_reg [2];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       pop;

    assign can_take  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign out_res   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_res;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/length_prefixed_bit_receiver.sv @@
`default_nettype none

// length-prefixed bit receiver
// input channel: item_valid / item_ready with sender_id and bit_value, one bit per item
// output channel: result_valid / result_ready, exactly one result item per input item,
//   carrying dest_id, ack_bit, ack_done, byte_valid, data_byte and rejected
// protocol: a one bit while idle locks onto its sender, then 32 length bits msb first,
//   then that many bytes msb first; a byte comes out on the bit that completes it and
//   ack_done marks the last bit (or the last header bit for a zero length)
// a zero bit while idle, or a bit from another sender while locked, is rejected and
//   the receiver falls back to idle
// path: an accepted item sits in the input register, then the state update writes its
//   result into the result queue, from which it is offered; while the queue is full the
//   item waits in the input register
// throughput: one item per cycle while item_ready is high, as each processed item updates
//   the counters and the byte shift register
// stall: a two-entry result queue lets item_ready stay high while one result waits;
//   item_ready drops only when the queue is full and the input register is occupied
// reset: idle, unlocked, input register and result queue empty
module length_prefixed_bit_receiver
    import lpbr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire logic [ID_BITS-1:0]   sender_id,
    input  wire logic                 bit_value,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output logic [ID_BITS-1:0]        dest_id,
    output logic                      ack_bit,
    output logic                      ack_done,
    output logic                      byte_valid,
    output logic [BYTE_BITS-1:0]      data_byte,
    output logic                      rejected
);

    // input register
    logic               stage_valid_reg;
    logic [ID_BITS-1:0] stage_id_reg;
    logic               stage_bit_reg;

    logic    advance;
    logic    can_take;
    result_t core_res;
    result_t out_res;

    // the staged item is processed as soon as the result queue has room
    assign advance    = stage_valid_reg && can_take;
    assign item_ready = !stage_valid_reg || can_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            stage_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            stage_id_reg  <= sender_id;
            stage_bit_reg <= bit_value;
        end
    end

    // protocol state and per-bit result
    lpbr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .sender_id (stage_id_reg),
        .bit_value (stage_bit_reg),
        .res       (core_res)
    );

    // result queue toward the receiver side
    lpbr_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .push_res  (core_res),
        .can_take  (can_take),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_res   (out_res)
    );

    assign dest_id    = out_res.dest_id;
    assign ack_bit    = out_res.ack_bit;
    assign ack_done   = out_res.ack_done;
    assign byte_valid = out_res.byte_valid;
    assign data_byte  = out_res.data_byte;
    assign rejected   = out_res.rejected;

    // a result is either acknowledged or rejected, never both
    a_ack_xor_reject: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> (core_res.ack_bit != core_res.rejected))
        else $error("result both acknowledged and rejected, or neither");

    // done only comes with an acknowledged bit
    a_done_has_ack: assert property (@(posedge clk) disable iff (!rst_n)
        advance && core_res.ack_done |-> core_res.ack_bit)
        else $error("done without bit acknowledgment");

    // data byte is zero unless a byte completed
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !core_res.byte_valid |-> core_res.data_byte == '0)
        else $error("data byte set without byte_valid");

    // a staged item that cannot advance stays staged
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && !can_take |=> stage_valid_reg && $stable(stage_id_reg)
            && $stable(stage_bit_reg))
        else $error("staged item lost while result queue full");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none

// bench for the length-prefixed bit receiver
// - stimulus is one bit per item; whole frames are built as a lock bit, 32 length bits
//   msb first and then the payload bytes msb first
// - every accepted item is run through a local copy of the receiver state, and the
//   expected result item is queued; results are checked in order, field by field
// - both handshake sides idle at random, with one stretch of back-to-back traffic
//   and one long output hold that fills the block and stalls its input
module testbench;
    import lpbr_pkg::*;

    localparam int GAP_PERCENT  = 31;
    localparam int TOTAL_ITEMS  = 950;
    // output hold long enough to fill the input register and the two-entry result queue
    localparam int HOLD_CYCLES  = 300;
    // longest legal quiet time is the output hold; allow several times that
    localparam int QUIET_LIMIT  = 2000;
    // extra wait after the last owed result, to catch stray results
    localparam int DRAIN_CYCLES = 8;
    localparam logic [ID_BITS-1:0] ID_MAX = '1;

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_ready;
    logic [ID_BITS-1:0]   sender_id;
    logic                 bit_value;
    logic                 result_valid;
    logic                 result_ready;
    logic [ID_BITS-1:0]   dest_id;
    logic                 ack_bit;
    logic                 ack_done;
    logic                 byte_valid;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 rejected;

    // random idling switches and the output hold request
    logic sender_gaps;
    logic receiver_gaps;
    logic hold_pending;

    int unsigned items_sent;
    int unsigned mismatch_count;

    // result items still owed by the block, oldest first
    result_t expected_acks[$];

    // payload bytes for the next frame
    logic [BYTE_BITS-1:0] frame_bytes[$];

    // local copy of the receiver state
    logic                   peer_locked;
    logic [ID_BITS-1:0]     peer;
    phase_t                 rx_phase;
    logic [HDR_CNT_W-1:0]   hdr_seen;
    logic [LENGTH_BITS-1:0] msg_len;
    logic [LENGTH_BITS-1:0] bytes_seen;
    logic [BIT_POS_W-1:0]   bit_pos;
    logic [BYTE_BITS-1:0]   shift_reg;

    length_prefixed_bit_receiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .sender_id    (sender_id),
        .bit_value    (bit_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .dest_id      (dest_id),
        .ack_bit      (ack_bit),
        .ack_done     (ack_done),
        .byte_valid   (byte_valid),
        .data_byte    (data_byte),
        .rejected     (rejected)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // receiver state tracking
    // ------------------------------------------------------------------

    task automatic clear_receiver();
        peer_locked = 1'b0;
        peer        = '0;
        rx_phase    = PH_IDLE;
        hdr_seen    = '0;
        msg_len     = '0;
        bytes_seen  = '0;
        bit_pos     = BIT_POS_TOP;
        shift_reg   = '0;
    endtask

    // advance the local state by one accepted bit and queue the result it owes
    task automatic track_receiver(input logic [ID_BITS-1:0] id, input logic b);
        result_t r;
        r         = '0;
        r.dest_id = id;
        if (!peer_locked || (rx_phase != PH_HEADER && rx_phase != PH_DATA))
        begin
            // idle: a one locks onto the sender, a zero is refused
            clear_receiver();
            if (b)
            begin
                peer_locked = 1'b1;
                peer        = id;
                rx_phase    = PH_HEADER;
                r.ack_bit   = 1'b1;
            end
            else
            begin
                r.rejected = 1'b1;
            end
        end
        else if (id != peer)
        begin
            // another sender cuts in: drop the frame
            clear_receiver();
            r.rejected = 1'b1;
        end
        else if (rx_phase == PH_HEADER)
        begin
            r.ack_bit = 1'b1;
            msg_len   = {msg_len[LENGTH_BITS-2:0], b};
            hdr_seen  = hdr_seen + 1'b1;
            if (hdr_seen >= HDR_CNT_LAST)
            begin
                if (msg_len == '0)
                begin
                    // empty message ends on the last header bit
                    r.ack_done = 1'b1;
                    clear_receiver();
                end
                else
                begin
                    rx_phase   = PH_DATA;
                    bytes_seen = '0;
                    bit_pos    = BIT_POS_TOP;
                    shift_reg  = '0;
                end
            end
        end
        else
        begin
            r.ack_bit = 1'b1;
            shift_reg = {shift_reg[BYTE_BITS-2:0], b};
            if (bit_pos == '0)
            begin
                r.byte_valid = 1'b1;
                r.data_byte  = shift_reg;
                shift_reg    = '0;
                bit_pos      = BIT_POS_TOP;
                bytes_seen   = bytes_seen + 1'b1;
                if (bytes_seen == msg_len)
                begin
                    r.ack_done = 1'b1;
                    clear_receiver();
                end
            end
            else
            begin
                bit_pos = bit_pos - 1'b1;
            end
        end
        expected_acks.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // offer one bit; called at a falling edge, returns at a falling edge
    task automatic send_bit(input logic [ID_BITS-1:0] id, input logic b);
        while (sender_gaps && $urandom_range(0, 99) < GAP_PERCENT)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        sender_id  <= id;
        bit_value  <= b;
        do
            @(posedge clk);
        while (!item_ready);
        track_receiver(id, b);
        items_sent++;
        @(negedge clk);
    endtask

    // lock bit, length field msb first, then frame_bytes msb first;
    // a non-negative cut stops after that many items
    task automatic send_frame(input logic [ID_BITS-1:0] id,
                              input logic [LENGTH_BITS-1:0] len_field,
                              input int cut);
        logic bit_stream[$];
        bit_stream.push_back(1'b1);
        for (int i = LENGTH_BITS - 1; i >= 0; i--)
            bit_stream.push_back(len_field[i]);
        foreach (frame_bytes[k])
            for (int i = BYTE_BITS - 1; i >= 0; i--)
                bit_stream.push_back(frame_bytes[k][i]);
        for (int n = 0; n < bit_stream.size() && (cut < 0 || n < cut); n++)
            send_bit(id, bit_stream[n]);
    endtask

    function automatic logic [ID_BITS-1:0] random_id();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return ID_MAX;
        else
            return ID_BITS'($urandom);
    endfunction

    // an id that differs from the given one in one random bit
    function automatic logic [ID_BITS-1:0] other_id(input logic [ID_BITS-1:0] id);
        return id ^ (ID_BITS'(1) << $urandom_range(0, ID_BITS - 1));
    endfunction

    task automatic fill_payload(input int count);
        int pick;
        frame_bytes.delete();
        repeat (count)
        begin
            pick = $urandom_range(0, 5);
            if (pick == 0)
                frame_bytes.push_back(8'h00);
            else if (pick == 1)
                frame_bytes.push_back(8'hFF);
            else
                frame_bytes.push_back(BYTE_BITS'($urandom));
        end
    endtask

    // bring the block back to idle with a foreign bit if a frame is open
    task automatic make_idle();
        if (peer_locked)
            send_bit(other_id(peer), 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // zero bits while idle are refused, at both id extremes
    task automatic test_idle_zero();
        send_bit('0, 1'b0);
        send_bit(ID_MAX, 1'b0);
    endtask

    // zero length: done comes with the last header bit
    task automatic test_zero_length();
        make_idle();
        frame_bytes.delete();
        send_frame(ID_MAX, '0, -1);
    endtask

    // full frame with all-zero and all-one bytes, ends with done on the last bit
    task automatic test_extreme_bytes();
        make_idle();
        frame_bytes.delete();
        frame_bytes.push_back(8'h00);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(8'h5A);
        send_frame('0, 3, -1);
    endtask

    // another sender cuts in during the header and during the data
    task automatic test_foreign_sender();
        make_idle();
        fill_payload(1);
        // largest length, cut five bits into the first byte
        send_frame(22'h2AAAAA, '1, 1 + LENGTH_BITS + 5);
        send_bit(22'h155555, 1'b1);
        // the block is idle again, so a zero from the interloper is refused
        send_bit(22'h155555, 1'b0);
        make_idle();
        // a top-bit length, cut inside the header by another sender
        send_frame(ID_MAX, 32'h8000_0001, 12);
        send_bit('0, 1'b0);
    endtask

    // a stretch with no idling on either side
    task automatic test_back_to_back();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        make_idle();
        fill_payload(3);
        send_frame(random_id(), 3, -1);
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering, so the block backs up
    task automatic test_output_stall();
        sender_gaps  = 1'b0;
        hold_pending = 1'b1;
        make_idle();
        fill_payload(4);
        send_frame(random_id(), 4, -1);
        sender_gaps  = 1'b1;
    endtask

    // mostly well-formed frames with random content, plus broken frames and noise
    task automatic test_random_traffic();
        logic [ID_BITS-1:0] id;
        int pick;
        int len;
        int span;
        while (items_sent < TOTAL_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            id   = random_id();
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
            fill_payload(len);
            if (pick < 70)
            begin
                make_idle();
                send_frame(id, len, -1);
            end
            else if (pick < 85)
            begin
                // frame cut short by another sender
                make_idle();
                span = 1 + LENGTH_BITS + BYTE_BITS * len;
                send_frame(id, len, $urandom_range(1, span - 1));
                send_bit(other_id(id), 1'($urandom_range(0, 1)));
            end
            else
            begin
                // loose bits from the current peer or a random sender
                repeat ($urandom_range(1, 4))
                    send_bit(($urandom_range(0, 1) != 0) ? id : peer, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // receiver side: random stalls, plus the long hold on request
    // ------------------------------------------------------------------

    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                result_ready <= !(receiver_gaps && $urandom_range(0, 99) < GAP_PERCENT);
            end
        end
    end

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : check_result
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_acks.size() == 0)
            begin
                $error("result item with nothing pending, dest_id %0h", dest_id);
                mismatch_count++;
            end
            else
            begin
                want = expected_acks.pop_front();
                if (dest_id !== want.dest_id)
                begin
                    $error("dest_id: expected %0h, got %0h", want.dest_id, dest_id);
                    mismatch_count++;
                end
                if (ack_bit !== want.ack_bit)
                begin
                    $error("ack_bit: expected %0b, got %0b", want.ack_bit, ack_bit);
                    mismatch_count++;
                end
                if (ack_done !== want.ack_done)
                begin
                    $error("ack_done: expected %0b, got %0b", want.ack_done, ack_done);
                    mismatch_count++;
                end
                if (byte_valid !== want.byte_valid)
                begin
                    $error("byte_valid: expected %0b, got %0b", want.byte_valid, byte_valid);
                    mismatch_count++;
                end
                if (data_byte !== want.data_byte)
                begin
                    $error("data_byte: expected %0h, got %0h", want.data_byte, data_byte);
                    mismatch_count++;
                end
                if (rejected !== want.rejected)
                begin
                    $error("rejected: expected %0b, got %0b", want.rejected, rejected);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long with no handshake on either side ends the run
    // ------------------------------------------------------------------

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL length_prefixed_bit_receiver");
        $finish;
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial
    begin
        item_valid     = 1'b0;
        sender_id      = '0;
        bit_value      = 1'b0;
        rst_n          = 1'b0;
        sender_gaps    = 1'b1;
        receiver_gaps  = 1'b1;
        hold_pending   = 1'b0;
        items_sent     = 0;
        mismatch_count = 0;
        clear_receiver();

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        test_idle_zero();
        test_zero_length();
        test_extreme_bytes();
        test_foreign_sender();
        test_back_to_back();
        test_output_stall();
        test_random_traffic();

        item_valid <= 1'b0;
        // drain: wait for every owed result, then keep watching for strays
        while (expected_acks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS length_prefixed_bit_receiver");
        else
            $display("FAIL length_prefixed_bit_receiver");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/lpbr_pkg.sv
hw/rtl/lpbr_core.sv
hw/rtl/lpbr_out_buf.sv
hw/rtl/length_prefixed_bit_receiver.sv
tb/testbench.sv
